/* rtl/pcpc_pkg.sv */
// ----------------------------------------------------------------------------
// pcpc_pkg: shared types and constants
// Register indexes, opcodes, control state encoding and fixed widths.
// ----------------------------------------------------------------------------
package pcpc_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd7;

    localparam logic OP_PULSE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [15:0] GATE_LO_US = 16'd500;
    localparam logic [15:0] GATE_HI_US = 16'd2500;

    // Widths of the serial datapath.
    localparam int MUL_A_W = 26;   // multiplicand magnitude (span of counts or error beyond dead band)
    localparam int MUL_B_W = 17;   // multiplier (pulse offset or gain)
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CNT_W   = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } ctl_state_t;

    // States of the shared serial arithmetic unit.
    typedef enum logic [1:0] {
        SU_IDLE,
        SU_MUL,
        SU_DIV,
        SU_DONE
    } su_state_t;

    // Request to the shared serial arithmetic unit.
    typedef struct packed {
        logic                 start;
        logic                 do_div;     // divide product by divisor after multiply
        logic [MUL_A_W-1:0]   mul_a;
        logic [MUL_B_W-1:0]   mul_b;
        logic [MUL_B_W-1:0]   divisor;
    } ser_req_t;

    typedef struct packed {
        logic               done;
        logic [PROD_W-1:0]  result;
    } ser_rsp_t;

endpackage

/* rtl/pcpc_serial_unit.sv */
// ----------------------------------------------------------------------------
// pcpc_serial_unit: bit-serial multiply and divide
// Shift-add multiply one bit a cycle, then optional restoring divide one
// quotient bit a cycle. Operands are unsigned magnitudes.
// ----------------------------------------------------------------------------
module pcpc_serial_unit
    import pcpc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  ser_req_t req,
    output ser_rsp_t rsp
);

    localparam int DIV_W = PROD_W;

    su_state_t              state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PROD_W-1:0]      acc_reg, acc_next;
    logic [PROD_W-1:0]      mcand_reg, mcand_next;
    logic [MUL_B_W-1:0]     mplier_reg, mplier_next;
    logic [MUL_B_W-1:0]     dvsr_reg, dvsr_next;
    logic                   dodiv_reg, dodiv_next;
    logic [MUL_B_W:0]       rem_reg, rem_next;
    logic [MUL_B_W:0]       rem_shift;

    always_comb begin
        rem_shift = {rem_reg[MUL_B_W-1:0], acc_reg[PROD_W-1]};
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dvsr_next   = dvsr_reg;
        dodiv_next  = dodiv_reg;
        rem_next    = rem_reg;
        case (state_reg)
            SU_IDLE: begin
                if (req.start) begin
                    acc_next    = '0;
                    mcand_next  = PROD_W'(req.mul_a);
                    mplier_next = req.mul_b;
                    dvsr_next   = req.divisor;
                    dodiv_next  = req.do_div;
                    cnt_next    = CNT_W'(MUL_B_W - 1);
                    state_next  = SU_MUL;
                end
            end
            SU_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (cnt_reg == '0) begin
                    rem_next = '0;
                    cnt_next = CNT_W'(DIV_W - 1);
                    state_next = dodiv_reg ? SU_DIV : SU_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            SU_DIV: begin
                // Quotient bits shift into the low end of acc.
                if (rem_shift >= {1'b0, dvsr_reg}) begin
                    rem_next = rem_shift - {1'b0, dvsr_reg};
                    acc_next = {acc_reg[PROD_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift;
                    acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    state_next = SU_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            SU_DONE: begin
                state_next = SU_IDLE;
            end
            default: begin
                state_next = SU_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dvsr_reg   <= dvsr_next;
        dodiv_reg  <= dodiv_next;
        rem_reg    <= rem_next;
    end

    assign rsp.done   = (state_reg == SU_DONE);
    assign rsp.result = acc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SU_DONE) |=> (state_reg == SU_IDLE))
        else $error("serial unit did not return to idle");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SU_DIV) |-> (dvsr_reg != '0))
        else $error("divide by zero in serial unit");
    a_done_one: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done)
        else $error("done held for more than one cycle");

endmodule

/* rtl/pwm_commanded_position_controller_top.sv */
// ----------------------------------------------------------------------------
// pwm_commanded_position_controller_top: pulse-commanded position controller
// Gates and maps command pulses to a target and regulates a speed command.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A sample item whose error falls in the
// braking ramp, and every accepted command pulse with a pulse range that is
// not empty, pass through a shared bit-serial unit: a shift-add multiply, and
// for pulses a further restoring divide. When m_valid rises, the input is
// ready again in that same cycle. A dropped pulse gives no result and frees
// the input. The result sits in an output register; while it waits for m_ready
// the next item is already worked on, and that item stalls only when its own
// result is due.
// Configuration is to be written through the plain write port only while the
// block is idle; the block itself does not enforce this. The brake gain
// division by the gain scale is a right shift, so the gain scale is given by
// its base-2 logarithm, GainScaleLog2.
// ----------------------------------------------------------------------------
module pwm_commanded_position_controller_top
    import pcpc_pkg::*;
#(
    parameter int DzExitMul     = 2,
    parameter int ReverseLock   = 200,
    parameter int GainScaleLog2 = 8,
    parameter int MinBrakeSpeed = 50,
    parameter int CruiseErr     = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [15:0]           s_pulse_width_us,
    input  logic signed [23:0]    s_position_count,
    input  logic [31:0]           s_time_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_speed_command,
    output logic                  m_is_settled,
    output logic                  m_is_holding
);

    localparam int EW = 27;  // error width, with guard bits

    // Configuration registers.
    logic [15:0]        pmin_reg, pmax_reg, dband_reg, gain_reg;
    logic signed [23:0] cmin_reg, cmax_reg;
    logic [14:0]        vlim_reg;
    logic [31:0]        tmo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pmin_reg  <= 16'd1000;
            pmax_reg  <= 16'd2000;
            cmin_reg  <= 24'sd0;
            cmax_reg  <= 24'sd4096;
            dband_reg <= 16'd20;
            gain_reg  <= 16'd256;
            vlim_reg  <= 15'd32767;
            tmo_reg   <= 32'd500;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PULSE_MIN:  pmin_reg  <= cfg_data[15:0];
                REG_PULSE_MAX:  pmax_reg  <= cfg_data[15:0];
                REG_COUNT_MIN:  cmin_reg  <= cfg_data[23:0];
                REG_COUNT_MAX:  cmax_reg  <= cfg_data[23:0];
                REG_DEAD_BAND:  dband_reg <= cfg_data[15:0];
                REG_BRAKE_GAIN: gain_reg  <= cfg_data[15:0];
                REG_SPEED_LIM:  vlim_reg  <= cfg_data[14:0];
                REG_TIMEOUT:    tmo_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Controller state.
    logic signed [23:0] target_reg, target_next;
    logic signed [23:0] filt_reg, filt_next;
    logic               primed_reg, primed_next;
    logic signed [15:0] speed_reg, speed_next;
    logic [1:0]         dir_reg, dir_next;      // 01 forward, 10 reverse
    logic               hold_reg, hold_next;
    logic               cvalid_reg, cvalid_next;
    logic               settled_reg, settled_next;
    logic [31:0]        lastms_reg, lastms_next;

    // Old target is kept until the pulse result is committed.
    logic signed [23:0] old_target_reg;

    // Latched item.
    logic               op_reg, op_next;
    logic [15:0]        pw_reg, pw_next;
    logic signed [23:0] pos_reg, pos_next;
    logic [31:0]        now_reg, now_next;

    // Values held between the start and end of a serial operation.
    logic               neg_reg, neg_next;      // sign of the pending product
    logic signed [EW-1:0] err_reg, err_next;

    ctl_state_t state_reg, state_next;
    logic       mv_reg, mv_next;

    ser_req_t req;
    ser_rsp_t rsp;

    pcpc_serial_unit u_ser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    function automatic logic [25:0] abs_diff(input logic signed [23:0] a,
                                             input logic signed [23:0] b);
        logic signed [25:0] d;
        d = 26'(a) - 26'(b);
        return d[25] ? 26'(-d) : 26'(d);
    endfunction

    // Derived thresholds.
    logic [16:0] dz;
    logic [21:0] dz_exit, cruise;
    logic [16:0] kp;
    always_comb begin
        dz      = (dband_reg == '0) ? 17'd1 : {1'b0, dband_reg};
        dz_exit = 22'(dz) * 22'(DzExitMul);
        cruise  = (22'(CruiseErr) <= dz_exit) ? dz_exit + 22'd1 : 22'(CruiseErr);
        kp      = (gain_reg == '0) ? 17'd1 : {1'b0, gain_reg};
    end

    // Pulse mapping operands.
    logic [15:0] pw_cl;
    logic signed [24:0] span_cnt;
    logic [24:0] span_mag;
    always_comb begin
        pw_cl = pw_reg;
        if (pw_cl < pmin_reg) pw_cl = pmin_reg;
        if (pw_cl > pmax_reg) pw_cl = pmax_reg;
        span_cnt = 25'(cmax_reg) - 25'(cmin_reg);
        span_mag = span_cnt[24] ? 25'(-span_cnt) : 25'(span_cnt);
    end

    // Sample stage: filter, timeout, error.
    logic signed [24:0] fsum;
    logic signed [23:0] filt_new;
    logic               to_hit;
    logic signed [EW-1:0] err;
    logic [EW-1:0]      aerr;
    always_comb begin
        fsum     = 25'(filt_reg) + 25'(pos_reg);
        filt_new = primed_reg ? 24'((fsum + 25'(fsum[24])) >>> 1) : pos_reg;
        to_hit   = cvalid_reg && ((now_reg - lastms_reg) > tmo_reg);
        err      = EW'(target_reg) - EW'(filt_new);
        aerr     = err[EW-1] ? EW'(-err) : EW'(err);
    end

    // Brake speed from product.
    logic [PROD_W-1:0] brk;
    logic [15:0]       spd_mag;
    logic signed [16:0] spd_s;
    logic signed [EW-1:0] err_h;
    always_comb begin
        err_h   = err_reg;
        brk     = rsp.result >> GainScaleLog2;
        if (brk > PROD_W'(vlim_reg)) brk = PROD_W'(vlim_reg);
        if (brk < PROD_W'(MinBrakeSpeed)) brk = PROD_W'(MinBrakeSpeed);
        if (brk > PROD_W'(vlim_reg)) brk = PROD_W'(vlim_reg);
        spd_mag = 16'(brk);
        spd_s   = err_h[EW-1] ? -17'(spd_mag) : 17'(spd_mag);
    end

    // Next state and datapath.
    logic [PROD_W-1:0] q_signed;
    always_comb begin
        state_next   = state_reg;
        mv_next      = mv_reg;
        target_next  = target_reg;
        filt_next    = filt_reg;
        primed_next  = primed_reg;
        speed_next   = speed_reg;
        dir_next     = dir_reg;
        hold_next    = hold_reg;
        cvalid_next  = cvalid_reg;
        settled_next = settled_reg;
        lastms_next  = lastms_reg;
        op_next      = op_reg;
        pw_next      = pw_reg;
        pos_next     = pos_reg;
        now_next     = now_reg;
        neg_next     = neg_reg;
        err_next     = err_reg;
        req          = '0;
        q_signed     = neg_reg ? PROD_W'(-rsp.result) : rsp.result;
        if (m_valid && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next  = s_opcode;
                    pw_next  = s_pulse_width_us;
                    pos_next = s_position_count;
                    now_next = s_time_ms;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (op_reg == OP_PULSE) begin
                    if (pw_reg < GATE_LO_US || pw_reg > GATE_HI_US) begin
                        state_next = ST_IDLE;
                    end else if (pmax_reg <= pmin_reg) begin
                        target_next = cmin_reg;
                        state_next  = ST_OUT;
                    end else begin
                        req.start   = 1'b1;
                        req.do_div  = 1'b1;
                        req.mul_a   = MUL_A_W'(span_mag);
                        req.mul_b   = MUL_B_W'(pw_cl - pmin_reg);
                        req.divisor = MUL_B_W'(pmax_reg - pmin_reg);
                        neg_next    = span_cnt[24];
                        state_next  = ST_DIV;
                    end
                end else begin
                    filt_next   = filt_new;
                    primed_next = 1'b1;
                    err_next    = err;
                    state_next  = ST_OUT;
                    if (to_hit) begin
                        hold_next   = 1'b1;
                        cvalid_next = 1'b0;
                    end
                    if (hold_reg || to_hit) begin
                        speed_next   = '0;
                        settled_next = 1'b1;
                        dir_next     = 2'b00;
                    end else if (settled_reg && aerr <= EW'(dz_exit)) begin
                        speed_next = '0;
                        dir_next   = 2'b00;
                    end else if (!settled_reg && aerr < EW'(dz)) begin
                        settled_next = 1'b1;
                        speed_next   = '0;
                        dir_next     = 2'b00;
                    end else begin
                        settled_next = 1'b0;
                        if (aerr < EW'(ReverseLock) &&
                            ((dir_reg == 2'b01 && err < 0) ||
                             (dir_reg == 2'b10 && err > 0))) begin
                            speed_next = '0;
                        end else if (aerr >= EW'(cruise)) begin
                            speed_next = err[EW-1] ? -16'(vlim_reg) : 16'(vlim_reg);
                            if (vlim_reg != '0) dir_next = err[EW-1] ? 2'b10 : 2'b01;
                        end else begin
                            req.start  = 1'b1;
                            req.do_div = 1'b0;
                            req.mul_a  = MUL_A_W'(aerr - EW'(dz));
                            req.mul_b  = kp;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                if (rsp.done) begin
                    speed_next = 16'(spd_s);
                    if (spd_s > 0) dir_next = 2'b01;
                    else if (spd_s < 0) dir_next = 2'b10;
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (rsp.done) begin
                    target_next = 24'(25'(cmin_reg) + 25'(q_signed));
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (op_reg == OP_PULSE) begin
                    if (abs_diff(target_reg, old_target_reg) > 26'(dband_reg)) begin
                        settled_next = 1'b0;
                    end
                    hold_next   = 1'b0;
                    cvalid_next = 1'b1;
                    lastms_next = now_reg;
                end
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic pulse_commit;
    assign pulse_commit = (state_reg == ST_OUT) && (op_reg == OP_PULSE)
                          && (!mv_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mv_reg      <= 1'b0;
            target_reg  <= '0;
            old_target_reg <= '0;
            filt_reg    <= '0;
            primed_reg  <= 1'b0;
            speed_reg   <= '0;
            dir_reg     <= 2'b00;
            hold_reg    <= 1'b0;
            cvalid_reg  <= 1'b0;
            settled_reg <= 1'b1;
            lastms_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            mv_reg      <= mv_next;
            target_reg  <= target_next;
            if (state_reg == ST_IDLE) old_target_reg <= target_reg;
            filt_reg    <= filt_next;
            primed_reg  <= primed_next;
            speed_reg   <= speed_next;
            dir_reg     <= dir_next;
            hold_reg    <= hold_next;
            cvalid_reg  <= cvalid_next;
            settled_reg <= (state_reg == ST_OUT && op_reg == OP_PULSE && !pulse_commit)
                           ? settled_reg : settled_next;
            lastms_reg  <= lastms_next;
        end
        op_reg  <= op_next;
        pw_reg  <= pw_next;
        pos_reg <= pos_next;
        now_reg <= now_next;
        neg_reg <= neg_next;
        err_reg <= err_next;
    end

    // Output register: loaded when a result is handed over.
    logic signed [15:0] o_speed_reg;
    logic               o_set_reg, o_hold_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!mv_reg || m_ready)) begin
            o_speed_reg <= speed_reg;
            o_set_reg   <= settled_next;
            o_hold_reg  <= hold_next;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = mv_reg;
    assign m_speed_command = o_speed_reg;
    assign m_is_settled    = o_set_reg;
    assign m_is_holding    = o_hold_reg;

    a_hold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg |-> (speed_reg == '0 || $past(state_reg) != ST_FINISH))
        else $error("speed not zero while holding");
    a_hold_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg |-> settled_reg)
        else $error("holding without being settled");
    a_dir_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        dir_reg != 2'b11)
        else $error("both drive directions set");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped under stall");

endmodule
